>>> design/svm_pkg.sv
// shared types and constants of the sample voice mixer
`default_nettype none
package svm_pkg;

    localparam int VOICES_DEF       = 8;
    localparam int SAMPLE_DEPTH_DEF = 16384;

    localparam int OP_W      = 2;
    localparam int ADDR_W    = 14;
    localparam int WORD_W    = 16;
    localparam int LEN_W     = 15;
    localparam int CNT_OUT_W = 4;
    localparam int SHIFT_W   = 3;

    localparam logic [SHIFT_W-1:0] SHIFT_RESET = 3'd2;
    localparam logic [WORD_W-1:0]  MIX_SILENT  = 16'd32768;
    localparam logic [WORD_W-1:0]  MIX_MIN     = 16'd0;
    localparam logic [WORD_W-1:0]  MIX_MAX     = 16'd65535;
    localparam int                 SAT_MIN     = -32768;
    localparam int                 SAT_MAX     = 32767;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD  = 2'd0,
        OP_START = 2'd1,
        OP_TICK  = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_VDATA,
        ST_SDATA,
        ST_MOVE
    } t_state;

    typedef struct packed {
        logic [WORD_W-1:0]    mixed;
        logic                 valid;
        logic                 accepted;
        logic [CNT_OUT_W-1:0] voices;
    } t_result;

endpackage
`default_nettype wire

>>> design/svm_ram.sv
// generic simple dual port ram with registered read
`default_nettype none
module svm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

>>> design/svm_mix_ctrl.sv
// item decode, voice table sequencer and mix accumulator
`default_nettype none
module svm_mix_ctrl
    import svm_pkg::*;
#(
    parameter int VOICES       = VOICES_DEF,
    parameter int SAMPLE_DEPTH = SAMPLE_DEPTH_DEF,
    localparam int AW   = $clog2(SAMPLE_DEPTH),
    localparam int EW   = AW + 1,
    localparam int VIW  = (VOICES > 1) ? $clog2(VOICES) : 1,
    localparam int VEW  = AW + EW
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    input  wire logic [OP_W-1:0]    i_op,
    input  wire logic [ADDR_W-1:0]  i_address,
    input  wire logic [WORD_W-1:0]  i_sample_word,
    input  wire logic [LEN_W-1:0]   i_voice_length,
    input  wire logic [SHIFT_W-1:0] i_shift,
    input  wire logic               i_out_free,
    output logic                    o_in_stall,
    output logic                    o_done,
    output t_result                 o_result,
    output logic                    o_smp_we,
    output logic      [AW-1:0]      o_smp_waddr,
    output logic      [WORD_W-1:0]  o_smp_wdata,
    output logic      [AW-1:0]      o_smp_raddr,
    input  wire logic [WORD_W-1:0]  i_smp_rdata,
    output logic                    o_vc_we,
    output logic      [VIW-1:0]     o_vc_waddr,
    output logic      [VEW-1:0]     o_vc_wdata,
    output logic      [VIW-1:0]     o_vc_raddr,
    input  wire logic [VEW-1:0]     i_vc_rdata
);

    localparam int CW   = $clog2(VOICES + 1);
    localparam int SW   = (EW > 16) ? EW : 16;
    localparam int ACCW = 18 + $clog2(VOICES);
    localparam logic signed [ACCW-1:0] LIM_LO = ACCW'(SAT_MIN);
    localparam logic signed [ACCW-1:0] LIM_HI = ACCW'(SAT_MAX);

    t_state                  r_state, n_state;
    logic [CW-1:0]           r_count, n_count;
    logic [VIW-1:0]          r_idx, n_idx;
    logic [AW-1:0]           r_pos, n_pos;
    logic [EW-1:0]           r_end, n_end;
    logic signed [ACCW-1:0]  r_acc, n_acc;

    logic              w_accept;
    logic              w_is_tick_busy;
    logic [SW-1:0]     w_sum_end;
    logic              w_load_ok;
    logic              w_start_ok;
    logic [AW-1:0]     w_rd_pos;
    logic [EW-1:0]     w_rd_end;
    logic [EW-1:0]     w_newpos;
    logic              w_retire;
    logic              w_last;
    logic              w_more;
    logic [16:0]       w_ext, w_mag, w_shr, w_att;
    logic signed [ACCW-1:0] w_acc_next;
    logic [WORD_W-1:0] w_mix;

    assign w_accept       = i_in_valid && (r_state == ST_IDLE) && i_out_free;
    assign o_in_stall     = !((r_state == ST_IDLE) && i_out_free);
    assign w_is_tick_busy = (i_op == OP_TICK) && (r_count != '0);

    assign w_sum_end  = SW'(i_address) + SW'(i_voice_length);
    assign w_load_ok  = SW'(i_address) < SW'(SAMPLE_DEPTH);
    assign w_start_ok = (r_count < CW'(VOICES)) && (i_voice_length != '0)
                        && (w_sum_end <= SW'(SAMPLE_DEPTH));

    assign w_rd_pos = i_vc_rdata[VEW-1 -: AW];
    assign w_rd_end = i_vc_rdata[EW-1:0];
    assign w_newpos = {1'b0, r_pos} + EW'(1);
    assign w_retire = w_newpos >= r_end;
    assign w_last   = CW'(r_idx) == (r_count - CW'(1));
    assign w_more   = (CW'(r_idx) + CW'(1)) < r_count;

    // truncate toward zero: shift the magnitude, then restore the sign
    assign w_ext = {i_smp_rdata[WORD_W-1], i_smp_rdata};
    assign w_mag = i_smp_rdata[WORD_W-1] ? (~w_ext + 17'd1) : w_ext;
    assign w_shr = w_mag >> i_shift;
    assign w_att = i_smp_rdata[WORD_W-1] ? (~w_shr + 17'd1) : w_shr;
    assign w_acc_next = r_acc + {{(ACCW-17){w_att[16]}}, w_att};

    always_comb begin
        if (w_acc_next < LIM_LO) begin
            w_mix = MIX_MIN;
        end else if (w_acc_next > LIM_HI) begin
            w_mix = MIX_MAX;
        end else begin
            w_mix = {~w_acc_next[15], w_acc_next[14:0]};
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept && w_is_tick_busy) begin
                    n_state = ST_VDATA;
                end
            end
            ST_VDATA: n_state = ST_SDATA;
            ST_SDATA: begin
                if (w_retire) begin
                    n_state = w_last ? ST_IDLE : ST_MOVE;
                end else begin
                    n_state = w_more ? ST_VDATA : ST_IDLE;
                end
            end
            ST_MOVE: n_state = ST_SDATA;
            default: n_state = ST_IDLE;
        endcase
    end

    // memory accesses and results
    always_comb begin
        o_smp_we    = 1'b0;
        o_smp_waddr = AW'(i_address);
        o_smp_wdata = i_sample_word;
        o_smp_raddr = w_rd_pos;
        o_vc_we     = 1'b0;
        o_vc_waddr  = r_idx;
        o_vc_wdata  = {w_newpos[AW-1:0], r_end};
        o_vc_raddr  = '0;
        o_done      = 1'b0;
        o_result.mixed    = MIX_SILENT;
        o_result.valid    = 1'b0;
        o_result.accepted = 1'b1;
        o_result.voices   = CNT_OUT_W'(r_count);
        case (r_state)
            ST_IDLE: begin
                o_smp_we   = w_accept && (i_op == OP_LOAD) && w_load_ok;
                o_vc_we    = w_accept && (i_op == OP_START) && w_start_ok;
                o_vc_waddr = VIW'(r_count);
                o_vc_wdata = {AW'(i_address), EW'(w_sum_end)};
                o_done     = w_accept && !w_is_tick_busy;
                o_result.valid = (i_op == OP_TICK);
                if (i_op == OP_START) begin
                    o_result.accepted = w_start_ok;
                    if (w_start_ok) begin
                        o_result.voices = CNT_OUT_W'(r_count + CW'(1));
                    end
                end else if (i_op == OP_NONE) begin
                    o_result.accepted = 1'b0;
                end
            end
            ST_VDATA: begin
            end
            ST_SDATA: begin
                o_result.mixed = w_mix;
                o_result.valid = 1'b1;
                if (w_retire) begin
                    // last voice moves into this slot and is visited next
                    o_vc_raddr = VIW'(r_count - CW'(1));
                    o_done     = w_last;
                    o_result.voices = CNT_OUT_W'(r_count - CW'(1));
                end else begin
                    o_vc_we    = 1'b1;
                    o_vc_raddr = r_idx + VIW'(1);
                    o_done     = !w_more;
                end
            end
            ST_MOVE: begin
                o_vc_we    = 1'b1;
                o_vc_wdata = i_vc_rdata;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_count = r_count;
        n_idx   = r_idx;
        n_pos   = r_pos;
        n_end   = r_end;
        n_acc   = r_acc;
        case (r_state)
            ST_IDLE: begin
                n_idx = '0;
                n_acc = '0;
                if (w_accept && (i_op == OP_START) && w_start_ok) begin
                    n_count = r_count + CW'(1);
                end
            end
            ST_VDATA, ST_MOVE: begin
                n_pos = w_rd_pos;
                n_end = w_rd_end;
            end
            ST_SDATA: begin
                n_acc = w_acc_next;
                if (w_retire) begin
                    n_count = r_count - CW'(1);
                end else begin
                    n_idx = r_idx + VIW'(1);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_idx   <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos <= n_pos;
        r_end <= n_end;
        r_acc <= n_acc;
    end

endmodule
`default_nettype wire

>>> design/sample_voice_mixer.sv
// top level of the polyphonic one-shot sample mixer
`default_nettype none
// Polyphonic one-shot sample mixer. Op load writes a signed word into the sample
// memory, op start adds a voice (refused when the table is full, the length is
// zero or the voice runs past the memory end), op tick mixes one word of every
// playing voice, each divided toward zero by 2^shift, saturated and sent as
// offset binary. Every item gives one result. Load, start, the unused op and a
// tick with no voice playing give their result at the accepting edge, and the
// block stays idle, ready for the next item. A tick with n playing voices keeps
// the input stalled until all n voices are mixed: each voice needs one
// voice-table read and one sample-memory read through single read ports with a
// registered read; a voice that moves into a retired slot takes its table read
// in place of the next slot's, so retiring adds no extra step. The input also
// stalls while a result waits in the result register under a stalled output; a
// result that leaves at an edge makes room for the next item at that same edge.
// There is no clearing pass after reset.
module sample_voice_mixer
    import svm_pkg::*;
#(
    parameter int VOICES       = VOICES_DEF,
    parameter int SAMPLE_DEPTH = SAMPLE_DEPTH_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [SHIFT_W-1:0]   i_cfg_data,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire logic [OP_W-1:0]      i_op,
    input  wire logic [ADDR_W-1:0]    i_address,
    input  wire logic [WORD_W-1:0]    i_sample_word,
    input  wire logic [LEN_W-1:0]     i_voice_length,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output logic      [WORD_W-1:0]    o_mixed_sample,
    output logic                      o_sample_valid,
    output logic                      o_accepted,
    output logic      [CNT_OUT_W-1:0] o_voices_active
);

    localparam int AW  = $clog2(SAMPLE_DEPTH);
    localparam int VIW = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int VEW = AW + AW + 1;

    logic [SHIFT_W-1:0] r_shift;
    t_result            r_out;
    logic               r_out_valid;

    logic               w_out_free;
    logic               w_done;
    t_result            w_result;
    logic               w_smp_we;
    logic [AW-1:0]      w_smp_waddr;
    logic [WORD_W-1:0]  w_smp_wdata;
    logic [AW-1:0]      w_smp_raddr;
    logic [WORD_W-1:0]  w_smp_rdata;
    logic               w_vc_we;
    logic [VIW-1:0]     w_vc_waddr;
    logic [VEW-1:0]     w_vc_wdata;
    logic [VIW-1:0]     w_vc_raddr;
    logic [VEW-1:0]     w_vc_rdata;

    assign o_cfg_ready = 1'b1;
    assign w_out_free  = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift <= SHIFT_RESET;
        end else if (i_cfg_valid) begin
            r_shift <= i_cfg_data;
        end
    end

    svm_ram #(
        .WIDTH (WORD_W),
        .DEPTH (SAMPLE_DEPTH)
    ) u_sample_ram (
        .i_clk   (i_clk),
        .i_we    (w_smp_we),
        .i_waddr (w_smp_waddr),
        .i_wdata (w_smp_wdata),
        .i_raddr (w_smp_raddr),
        .o_rdata (w_smp_rdata)
    );

    svm_ram #(
        .WIDTH (VEW),
        .DEPTH (VOICES)
    ) u_voice_ram (
        .i_clk   (i_clk),
        .i_we    (w_vc_we),
        .i_waddr (w_vc_waddr),
        .i_wdata (w_vc_wdata),
        .i_raddr (w_vc_raddr),
        .o_rdata (w_vc_rdata)
    );

    svm_mix_ctrl #(
        .VOICES       (VOICES),
        .SAMPLE_DEPTH (SAMPLE_DEPTH)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_op           (i_op),
        .i_address      (i_address),
        .i_sample_word  (i_sample_word),
        .i_voice_length (i_voice_length),
        .i_shift        (r_shift),
        .i_out_free     (w_out_free),
        .o_in_stall     (o_in_stall),
        .o_done         (w_done),
        .o_result       (w_result),
        .o_smp_we       (w_smp_we),
        .o_smp_waddr    (w_smp_waddr),
        .o_smp_wdata    (w_smp_wdata),
        .o_smp_raddr    (w_smp_raddr),
        .i_smp_rdata    (w_smp_rdata),
        .o_vc_we        (w_vc_we),
        .o_vc_waddr     (w_vc_waddr),
        .o_vc_wdata     (w_vc_wdata),
        .o_vc_raddr     (w_vc_raddr),
        .i_vc_rdata     (w_vc_rdata)
    );

    // result register, holds while the output transaction is stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_done) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_mixed_sample  = r_out.mixed;
    assign o_sample_valid  = r_out.valid;
    assign o_accepted      = r_out.accepted;
    assign o_voices_active = r_out.voices;

endmodule
`default_nettype wire

>>> bench/tb_sample_voice_mixer.sv
// testbench for sample_voice_mixer: directed and random traffic checked against a behavioral mixer
`timescale 1ns / 100ps
module tb_sample_voice_mixer
    import svm_pkg::*;
();

    localparam int HALF_PERIOD    = 6;
    localparam int RESET_CYCLES   = 9;
    localparam int HOLD_CYCLES    = 200;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int SETTLE_CYCLES  = 40;
    localparam int MAX_RUN        = 24;
    localparam int LAST_ADDR      = SAMPLE_DEPTH_DEF - 1;
    localparam int MAX_LEN_FIELD  = (1 << LEN_W) - 1;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [SHIFT_W-1:0]   i_cfg_data;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic [OP_W-1:0]      i_op;
    logic [ADDR_W-1:0]    i_address;
    logic [WORD_W-1:0]    i_sample_word;
    logic [LEN_W-1:0]     i_voice_length;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic [WORD_W-1:0]    o_mixed_sample;
    logic                 o_sample_valid;
    logic                 o_accepted;
    logic [CNT_OUT_W-1:0] o_voices_active;

    // behavioral copy of the mixer state
    logic [WORD_W-1:0]  mem_words [SAMPLE_DEPTH_DEF];
    int                 voice_pos [VOICES_DEF];
    int                 voice_stop [VOICES_DEF];
    int                 voice_count;
    logic [SHIFT_W-1:0] atten_shift;

    t_result mix_results_due [$];
    t_result mix_head;
    int      run_base [$];
    int      run_len [$];
    int      items_sent;
    int      errors;
    int      stuck_cycles;
    bit      jitter_on = 1'b1;
    bit      hold_request = 1'b0;

    sample_voice_mixer i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_op            (i_op),
        .i_address       (i_address),
        .i_sample_word   (i_sample_word),
        .i_voice_length  (i_voice_length),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_mixed_sample  (o_mixed_sample),
        .o_sample_valid  (o_sample_valid),
        .o_accepted      (o_accepted),
        .o_voices_active (o_voices_active)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    function automatic t_result mixer_step(t_op op, logic [ADDR_W-1:0] addr,
                                           logic [WORD_W-1:0] word, logic [LEN_W-1:0] len);
        t_result r;
        int      sum;
        int      s;
        int      j;
        r.mixed    = MIX_SILENT;
        r.valid    = 1'b0;
        r.accepted = 1'b1;
        case (op)
            OP_LOAD: mem_words[addr] = word;
            OP_START: begin
                if (voice_count >= VOICES_DEF || len == '0 ||
                    int'(addr) + int'(len) > SAMPLE_DEPTH_DEF) begin
                    r.accepted = 1'b0;
                end else begin
                    voice_pos[voice_count]  = int'(addr);
                    voice_stop[voice_count] = int'(addr) + int'(len);
                    voice_count++;
                end
            end
            OP_TICK: begin
                sum = 0;
                j   = 0;
                while (j < voice_count) begin
                    s = int'($signed(mem_words[voice_pos[j]]));
                    // shift the magnitude so the division truncates toward zero
                    if (s < 0) begin
                        sum -= (-s) >> atten_shift;
                    end else begin
                        sum += s >> atten_shift;
                    end
                    voice_pos[j]++;
                    if (voice_pos[j] >= voice_stop[j]) begin
                        // last voice takes this slot and still plays in this tick
                        voice_count--;
                        voice_pos[j]  = voice_pos[voice_count];
                        voice_stop[j] = voice_stop[voice_count];
                    end else begin
                        j++;
                    end
                end
                if (sum < SAT_MIN) begin
                    r.mixed = MIX_MIN;
                end else if (sum > SAT_MAX) begin
                    r.mixed = MIX_MAX;
                end else begin
                    r.mixed = WORD_W'(sum - SAT_MIN);
                end
                r.valid = 1'b1;
            end
            default: r.accepted = 1'b0;
        endcase
        r.voices = CNT_OUT_W'(voice_count);
        return r;
    endfunction

    task automatic issue_item(input t_op op, input int addr, input int word, input int len);
        int      gap;
        t_result want;
        gap = (jitter_on && $urandom_range(0, 5) == 0) ? $urandom_range(1, 9) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_op           <= op;
        i_address      <= ADDR_W'(addr);
        i_sample_word  <= WORD_W'(word);
        i_voice_length <= LEN_W'(len);
        do @(posedge i_clk); while (o_in_stall);
        want = mixer_step(op, ADDR_W'(addr), WORD_W'(word), LEN_W'(len));
        mix_results_due.push_back(want);
        if (op != OP_NONE) items_sent++;
    endtask

    // wait until every transaction has come back and the block is quiet
    task automatic settle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (mix_results_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_shift(input logic [SHIFT_W-1:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        atten_shift = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic issue_ticks(input int count);
        repeat (count) issue_item(OP_TICK, $urandom_range(0, LAST_ADDR), $urandom,
                                  $urandom_range(0, MAX_LEN_FIELD));
    endtask

    task automatic load_run(input int base, input int count);
        int word;
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(0, 3) == 0) begin
                word = $urandom_range(0, 1) ? 32'h0000_7FFF : 32'hFFFF_8000;
            end else begin
                word = $urandom;
            end
            issue_item(OP_LOAD, base + k, word, $urandom_range(0, MAX_LEN_FIELD));
        end
        run_base.push_back(base);
        run_len.push_back(count);
    endtask

    // a start that only covers loaded words
    task automatic start_in_run(input int idx);
        int offset;
        offset = $urandom_range(0, run_len[idx] - 1);
        issue_item(OP_START, run_base[idx] + offset, $urandom,
                   $urandom_range(1, run_len[idx] - offset));
    endtask

    // a start that must be refused: zero length or running past the memory end
    task automatic noise_start();
        int len;
        int lo;
        int addr;
        len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, MAX_LEN_FIELD);
        if (len == 0) begin
            addr = $urandom_range(0, LAST_ADDR);
        end else begin
            lo   = (len > SAMPLE_DEPTH_DEF) ? 0 : SAMPLE_DEPTH_DEF + 1 - len;
            addr = $urandom_range(lo, LAST_ADDR);
        end
        issue_item(OP_START, addr, $urandom, len);
    endtask

    task automatic test_idle_block();
        issue_item(OP_NONE, LAST_ADDR, 32'hFFFF, MAX_LEN_FIELD);
        issue_item(OP_TICK, 0, 0, 0);
        settle();
    endtask

    task automatic test_refused_starts();
        issue_item(OP_LOAD, 0, 32'h0000_7FFF, 0);
        issue_item(OP_LOAD, 1, 32'h0000_7FFF, 0);
        issue_item(OP_LOAD, 2, 32'hFFFF_8000, 0);
        issue_item(OP_LOAD, 3, 32'hFFFF_8000, 0);
        issue_item(OP_LOAD, LAST_ADDR - 1, -3, 0);
        issue_item(OP_LOAD, LAST_ADDR, -1, 0);
        run_base.push_back(0);
        run_len.push_back(4);
        run_base.push_back(LAST_ADDR - 1);
        run_len.push_back(2);
        issue_item(OP_START, 0, 0, 0);
        issue_item(OP_START, LAST_ADDR, 0, 2);
        issue_item(OP_START, LAST_ADDR, 0, MAX_LEN_FIELD);
        // small negative words shrink to zero, not to -1
        issue_item(OP_START, LAST_ADDR - 1, 0, 2);
        issue_ticks(2);
        settle();
    endtask

    task automatic test_saturation();
        write_shift(3'd0);
        issue_item(OP_START, 0, 0, 2);
        issue_item(OP_START, 1, 0, 1);
        issue_ticks(2);
        issue_item(OP_START, 2, 0, 2);
        issue_item(OP_START, 2, 0, 2);
        issue_ticks(2);
        settle();
    endtask

    task automatic test_table_full();
        write_shift(3'd7);
        repeat (VOICES_DEF + 1) start_in_run($urandom_range(0, 1));
        issue_ticks(4);
        settle();
    endtask

    task automatic test_output_hold();
        repeat (3) start_in_run($urandom_range(0, run_base.size() - 1));
        hold_request = 1'b1;
        repeat (30) begin
            if ($urandom_range(0, 1)) begin
                issue_ticks(1);
            end else begin
                issue_item(OP_LOAD, $urandom_range(0, LAST_ADDR), $urandom, 0);
            end
        end
        settle();
    endtask

    task automatic test_random_traffic(input int n_items);
        int target;
        int pick;
        int count;
        target = items_sent + n_items;
        while (items_sent < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                count = $urandom_range(1, MAX_RUN);
                load_run($urandom_range(0, SAMPLE_DEPTH_DEF - count), count);
                repeat ($urandom_range(1, 3)) start_in_run(run_base.size() - 1);
                issue_ticks($urandom_range(1, 20));
            end else if (pick < 75) begin
                repeat ($urandom_range(1, 4)) start_in_run($urandom_range(0, run_base.size() - 1));
                issue_ticks($urandom_range(1, 20));
            end else if (pick < 85) begin
                noise_start();
            end else if (pick < 90) begin
                issue_item(OP_NONE, $urandom_range(0, LAST_ADDR), $urandom,
                           $urandom_range(0, MAX_LEN_FIELD));
            end else begin
                issue_ticks($urandom_range(1, 5));
            end
        end
        settle();
    endtask

    // receiver pacing: random stall bursts plus one long hold-off on request
    initial begin
        int hold_left;
        int burst_left;
        hold_left   = 0;
        burst_left  = 0;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (burst_left > 0) begin
                burst_left--;
                i_out_stall <= 1'b1;
            end else if (jitter_on && $urandom_range(0, 7) == 0) begin
                burst_left = $urandom_range(0, 8);
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (o_out_valid && !i_out_stall) begin
            if (mix_results_due.size() == 0) begin
                $display("%0t: unexpected transaction, expected none, actual %0d %0b %0b %0d",
                         $time, o_mixed_sample, o_sample_valid, o_accepted, o_voices_active);
                errors++;
            end else begin
                mix_head = mix_results_due.pop_front();
                if (o_mixed_sample !== mix_head.mixed) begin
                    $display("%0t: mixed_sample expected %0d actual %0d",
                             $time, mix_head.mixed, o_mixed_sample);
                    errors++;
                end
                if (o_sample_valid !== mix_head.valid) begin
                    $display("%0t: sample_valid expected %0b actual %0b",
                             $time, mix_head.valid, o_sample_valid);
                    errors++;
                end
                if (o_accepted !== mix_head.accepted) begin
                    $display("%0t: accepted expected %0b actual %0b",
                             $time, mix_head.accepted, o_accepted);
                    errors++;
                end
                if (o_voices_active !== mix_head.voices) begin
                    $display("%0t: voices_active expected %0d actual %0d",
                             $time, mix_head.voices, o_voices_active);
                    errors++;
                end
            end
        end
    end

    // watchdog: too long without any transaction on any channel
    initial begin
        stuck_cycles = 0;
        while (stuck_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
                (i_cfg_valid && o_cfg_ready)) begin
                stuck_cycles = 0;
            end else begin
                stuck_cycles++;
            end
        end
        $display("tb: failure");
        $finish;
    end

    initial begin
        i_rst_n        = 1'b0;
        i_cfg_valid    = 1'b0;
        i_cfg_data     = SHIFT_RESET;
        i_in_valid     = 1'b0;
        i_op           = OP_NONE;
        i_address      = '0;
        i_sample_word  = '0;
        i_voice_length = '0;
        voice_count    = 0;
        atten_shift    = SHIFT_RESET;
        items_sent     = 0;
        errors         = 0;
        for (int v = 0; v < VOICES_DEF; v++) begin
            voice_pos[v]  = 0;
            voice_stop[v] = 0;
        end
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_idle_block();
        test_refused_starts();
        test_saturation();
        test_table_full();
        write_shift(3'd1);
        test_random_traffic(220);
        write_shift(3'd4);
        test_output_hold();
        test_random_traffic(200);
        write_shift(SHIFT_W'($urandom_range(0, 7)));
        test_random_traffic(150);
        // no idling on either side for the last stretch
        jitter_on = 1'b0;
        write_shift(SHIFT_W'($urandom_range(0, 3)));
        test_random_traffic(100);

        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

>>> files.f
design/svm_pkg.sv
design/svm_ram.sv
design/svm_mix_ctrl.sv
design/sample_voice_mixer.sv
bench/tb_sample_voice_mixer.sv
